// ===== hw/rtl/segment_intersect_2d_unit_macros.svh =====
// Assertion macros used by segment_intersect_2d_unit.sv.
`ifndef SEGMENT_INTERSECT_2D_UNIT_MACROS_SVH
`define SEGMENT_INTERSECT_2D_UNIT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define SID2_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle during reset.
`define SID2_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sid2_pkg.sv =====
`default_nettype none
package sid2_pkg;

  // Defaults and fixed widths.
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int OUT_W          = 24;

  // Result classification.
  typedef enum logic [1:0] {
    OC_CROSS     = 2'd0,
    OC_COLLINEAR = 2'd1,
    OC_PARALLEL  = 2'd2,
    OC_OUTSIDE   = 2'd3
  } outcome_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sid2_in_if.sv =====
`default_nettype none
interface sid2_in_if #(
  parameter int COORD_BITS = sid2_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_start_x;
  logic signed [COORD_BITS-1:0] a_start_y;
  logic signed [COORD_BITS-1:0] a_end_x;
  logic signed [COORD_BITS-1:0] a_end_y;
  logic signed [COORD_BITS-1:0] b_start_x;
  logic signed [COORD_BITS-1:0] b_start_y;
  logic signed [COORD_BITS-1:0] b_end_x;
  logic signed [COORD_BITS-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

interface sid2_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  sid2_pkg::outcome_t              outcome;
  logic signed [sid2_pkg::OUT_W-1:0] cross_x;
  logic signed [sid2_pkg::OUT_W-1:0] cross_y;

  modport source (output valid, hit, outcome, cross_x, cross_y, input ready);
  modport sink   (input valid, hit, outcome, cross_x, cross_y, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/segment_intersect_2d_unit.sv =====
`default_nettype none
// Channel   Role    Handshake      Item
// in_ch     sink    valid/ready    two segments, eight signed coordinates
// out_ch    source  valid/ready    hit, outcome, cross_x, cross_y
//
// One item per cycle sustained while out_ch.ready stays high; the pipeline is
// five setup stages, one divider stage per quotient bit, and an output register.
// The restoring divider, one quotient bit per stage, sets the depth.
// rst_n is synchronous, active low, and clears only the stage valid bits.
// Each stage holds while the one after it is full and stalled; empty stages
// keep filling, so items enter while a result waits at the output.
module segment_intersect_2d_unit #(
  parameter int COORD_BITS = sid2_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sid2_pkg::FRAC_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  sid2_in_if.sink     in_ch,
  sid2_out_if.source  out_ch
);
  import sid2_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int FB   = FRAC_BITS;
  localparam int DW   = CB + 1;            // coordinate differences
  localparam int PW   = 2 * DW;            // products
  localparam int SW   = PW + 1;            // den / numerators
  localparam int NW   = SW + DW + FB;      // dividend
  localparam int QW   = CB + FB;           // quotient
  localparam int EW   = (CB + FB + 2 > OUT_W) ? CB + FB + 2 : OUT_W;
  localparam int NS   = QW + 6;            // stages with a valid bit
  localparam int DV0  = 5;                 // first divider stage index

  // Stage valid bits and per-stage load enables
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ch.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: differences, start points, A sum for the midpoint
  logic signed [DW-1:0] s1_adx_r, s1_ady_r, s1_bdx_r, s1_bdy_r, s1_ox_r, s1_oy_r;
  logic signed [DW-1:0] s1_midx_r, s1_midy_r;
  logic signed [CB-1:0] s1_asx_r, s1_asy_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_adx_r  <= DW'(in_ch.a_end_x) - DW'(in_ch.a_start_x);
      s1_ady_r  <= DW'(in_ch.a_end_y) - DW'(in_ch.a_start_y);
      s1_bdx_r  <= DW'(in_ch.b_end_x) - DW'(in_ch.b_start_x);
      s1_bdy_r  <= DW'(in_ch.b_end_y) - DW'(in_ch.b_start_y);
      s1_ox_r   <= DW'(in_ch.a_start_x) - DW'(in_ch.b_start_x);
      s1_oy_r   <= DW'(in_ch.a_start_y) - DW'(in_ch.b_start_y);
      s1_midx_r <= DW'(in_ch.a_start_x) + DW'(in_ch.a_end_x);
      s1_midy_r <= DW'(in_ch.a_start_y) + DW'(in_ch.a_end_y);
      s1_asx_r  <= in_ch.a_start_x;
      s1_asy_r  <= in_ch.a_start_y;
    end
  end

  // Stage 2: the six cross products
  logic signed [PW-1:0] s2_d1_r, s2_d2_r, s2_a1_r, s2_a2_r, s2_b1_r, s2_b2_r;
  logic signed [DW-1:0] s2_adx_r, s2_ady_r, s2_midx_r, s2_midy_r;
  logic signed [CB-1:0] s2_asx_r, s2_asy_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_d1_r   <= PW'(s1_bdy_r) * PW'(s1_adx_r);
      s2_d2_r   <= PW'(s1_bdx_r) * PW'(s1_ady_r);
      s2_a1_r   <= PW'(s1_bdx_r) * PW'(s1_oy_r);
      s2_a2_r   <= PW'(s1_bdy_r) * PW'(s1_ox_r);
      s2_b1_r   <= PW'(s1_adx_r) * PW'(s1_oy_r);
      s2_b2_r   <= PW'(s1_ady_r) * PW'(s1_ox_r);
      s2_adx_r  <= s1_adx_r;
      s2_ady_r  <= s1_ady_r;
      s2_midx_r <= s1_midx_r;
      s2_midy_r <= s1_midy_r;
      s2_asx_r  <= s1_asx_r;
      s2_asy_r  <= s1_asy_r;
    end
  end

  // Stage 3: denominator and numerators
  logic signed [SW-1:0] s3_den_r, s3_na_r, s3_nb_r;
  logic signed [DW-1:0] s3_adx_r, s3_ady_r, s3_midx_r, s3_midy_r;
  logic signed [CB-1:0] s3_asx_r, s3_asy_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_den_r  <= SW'(s2_d1_r) - SW'(s2_d2_r);
      s3_na_r   <= SW'(s2_a1_r) - SW'(s2_a2_r);
      s3_nb_r   <= SW'(s2_b1_r) - SW'(s2_b2_r);
      s3_adx_r  <= s2_adx_r;
      s3_ady_r  <= s2_ady_r;
      s3_midx_r <= s2_midx_r;
      s3_midy_r <= s2_midy_r;
      s3_asx_r  <= s2_asx_r;
      s3_asy_r  <= s2_asy_r;
    end
  end

  // Stage 4: classify, magnitudes and result signs
  logic     den_zero, na_zero, nb_zero, a_in, b_in;
  outcome_t cls_nxt;

  always_comb begin
    den_zero = (s3_den_r == '0);
    na_zero  = (s3_na_r == '0);
    nb_zero  = (s3_nb_r == '0);
    if (s3_den_r > 0) begin
      a_in = (s3_na_r >= 0) && (s3_na_r <= s3_den_r);
      b_in = (s3_nb_r >= 0) && (s3_nb_r <= s3_den_r);
    end else begin
      a_in = (s3_na_r <= 0) && (s3_na_r >= s3_den_r);
      b_in = (s3_nb_r <= 0) && (s3_nb_r >= s3_den_r);
    end
    priority if (den_zero && na_zero && nb_zero) cls_nxt = OC_COLLINEAR;
    else if (den_zero)                           cls_nxt = OC_PARALLEL;
    else if (!a_in || !b_in)                     cls_nxt = OC_OUTSIDE;
    else                                         cls_nxt = OC_CROSS;
  end

  logic [SW-1:0]        s4_mna_r, s4_mden_r;
  logic [DW-1:0]        s4_madx_r, s4_mady_r;
  logic                 s4_negx_r, s4_negy_r;
  outcome_t             s4_cls_r;
  logic signed [DW-1:0] s4_midx_r, s4_midy_r;
  logic signed [CB-1:0] s4_asx_r, s4_asy_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_mna_r  <= s3_na_r[SW-1]  ? SW'(-s3_na_r)  : SW'(s3_na_r);
      s4_mden_r <= s3_den_r[SW-1] ? SW'(-s3_den_r) : SW'(s3_den_r);
      s4_madx_r <= s3_adx_r[DW-1] ? DW'(-s3_adx_r) : DW'(s3_adx_r);
      s4_mady_r <= s3_ady_r[DW-1] ? DW'(-s3_ady_r) : DW'(s3_ady_r);
      s4_negx_r <= s3_adx_r[DW-1] ^ s3_na_r[SW-1] ^ s3_den_r[SW-1];
      s4_negy_r <= s3_ady_r[DW-1] ^ s3_na_r[SW-1] ^ s3_den_r[SW-1];
      s4_cls_r  <= cls_nxt;
      s4_midx_r <= s3_midx_r;
      s4_midy_r <= s3_midy_r;
      s4_asx_r  <= s3_asx_r;
      s4_asy_r  <= s3_asy_r;
    end
  end

  // Stage 5 and divider: entry 0 is loaded with the dividends,
  // entry j+1 holds the item after quotient bit QW-1-j
  logic [NW-1:0]        d_remx_r [QW+1];
  logic [NW-1:0]        d_remy_r [QW+1];
  logic [QW-1:0]        d_qx_r   [QW+1];
  logic [QW-1:0]        d_qy_r   [QW+1];
  logic [SW-1:0]        d_den_r  [QW+1];
  logic                 d_negx_r [QW+1];
  logic                 d_negy_r [QW+1];
  outcome_t             d_cls_r  [QW+1];
  logic signed [DW-1:0] d_midx_r [QW+1];
  logic signed [DW-1:0] d_midy_r [QW+1];
  logic signed [CB-1:0] d_asx_r  [QW+1];
  logic signed [CB-1:0] d_asy_r  [QW+1];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      d_remx_r[0] <= (NW'(s4_mna_r) * NW'(s4_madx_r)) << FB;
      d_remy_r[0] <= (NW'(s4_mna_r) * NW'(s4_mady_r)) << FB;
      d_qx_r[0]   <= '0;
      d_qy_r[0]   <= '0;
      d_den_r[0]  <= s4_mden_r;
      d_negx_r[0] <= s4_negx_r;
      d_negy_r[0] <= s4_negy_r;
      d_cls_r[0]  <= s4_cls_r;
      d_midx_r[0] <= s4_midx_r;
      d_midy_r[0] <= s4_midy_r;
      d_asx_r[0]  <= s4_asx_r;
      d_asy_r[0]  <= s4_asy_r;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [NW:0] tx, ty;

    // Trial subtract of the divisor aligned to this quotient bit
    assign tx = {1'b0, d_remx_r[j]} - ((NW+1)'(d_den_r[j]) << B);
    assign ty = {1'b0, d_remy_r[j]} - ((NW+1)'(d_den_r[j]) << B);

    always_ff @(posedge clk) begin
      if (en[DV0+j]) begin
        d_remx_r[j+1] <= tx[NW] ? d_remx_r[j] : tx[NW-1:0];
        d_remy_r[j+1] <= ty[NW] ? d_remy_r[j] : ty[NW-1:0];
        d_qx_r[j+1]   <= {d_qx_r[j][QW-2:0], !tx[NW]};
        d_qy_r[j+1]   <= {d_qy_r[j][QW-2:0], !ty[NW]};
        d_den_r[j+1]  <= d_den_r[j];
        d_negx_r[j+1] <= d_negx_r[j];
        d_negy_r[j+1] <= d_negy_r[j];
        d_cls_r[j+1]  <= d_cls_r[j];
        d_midx_r[j+1] <= d_midx_r[j];
        d_midy_r[j+1] <= d_midy_r[j];
        d_asx_r[j+1]  <= d_asx_r[j];
        d_asy_r[j+1]  <= d_asy_r[j];
      end
    end
  end

  // Output stage: sign the offset, add the start, select by class
  logic signed [EW-1:0] offx, offy, crossx, crossy, midx, midy;

  always_comb begin
    offx   = EW'($signed({1'b0, d_qx_r[QW]}));
    offy   = EW'($signed({1'b0, d_qy_r[QW]}));
    crossx = (EW'(d_asx_r[QW]) <<< FB) + (d_negx_r[QW] ? -offx : offx);
    crossy = (EW'(d_asy_r[QW]) <<< FB) + (d_negy_r[QW] ? -offy : offy);
    midx   = EW'(d_midx_r[QW]) <<< (FB - 1);
    midy   = EW'(d_midy_r[QW]) <<< (FB - 1);
  end

  logic                    out_hit_r;
  outcome_t                out_cls_r;
  logic signed [OUT_W-1:0] out_x_r, out_y_r;

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_cls_r <= d_cls_r[QW];
      unique case (d_cls_r[QW])
        OC_CROSS: begin
          out_hit_r <= 1'b1;
          out_x_r   <= crossx[OUT_W-1:0];
          out_y_r   <= crossy[OUT_W-1:0];
        end
        OC_COLLINEAR: begin
          out_hit_r <= 1'b1;
          out_x_r   <= midx[OUT_W-1:0];
          out_y_r   <= midy[OUT_W-1:0];
        end
        default: begin
          out_hit_r <= 1'b0;
          out_x_r   <= '0;
          out_y_r   <= '0;
        end
      endcase
    end
  end

  assign out_ch.valid   = v_r[NS-1];
  assign out_ch.hit     = out_hit_r;
  assign out_ch.outcome = out_cls_r;
  assign out_ch.cross_x = out_x_r;
  assign out_ch.cross_y = out_y_r;

  // Checks
`include "segment_intersect_2d_unit_macros.svh"
  `SID2_ASSERT_NOW(a_hit_class, clk, rst_n, out_ch.valid,
    out_ch.hit == (out_ch.outcome == OC_CROSS || out_ch.outcome == OC_COLLINEAR),
    "hit disagrees with outcome")
  `SID2_ASSERT_NOW(a_miss_zero, clk, rst_n, out_ch.valid && !out_ch.hit,
    out_ch.cross_x == '0 && out_ch.cross_y == '0,
    "miss with nonzero point")
  `SID2_ASSERT_NOW(a_ready_only_full, clk, rst_n, !in_ch.ready,
    out_ch.valid && !out_ch.ready,
    "input held off with output not stalled")
endmodule
`default_nettype wire
